/* sv/pps_pkg.sv */
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and constants for the polyline point store.
// ----------------------------------------------------------------------------
`default_nettype none
package pps_pkg;
    localparam int MaxPoints = 1024;
    localparam int MaxLines  = 256;
    localparam int PAW = $clog2(MaxPoints);
    localparam int LAW = $clog2(MaxLines);
    localparam int PCW = $clog2(MaxPoints + 1);
    localparam int LCW = $clog2(MaxLines + 1);
    localparam int DW  = 33;

    localparam logic [2:0] K_APPEND = 3'd0;
    localparam logic [2:0] K_START  = 3'd1;
    localparam logic [2:0] K_UPDATE = 3'd2;
    localparam logic [2:0] K_DELETE = 3'd3;
    localparam logic [2:0] K_SEARCH = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_INDEX = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic [2:0]        kind;
        logic signed [15:0] coord_x;
        logic signed [15:0] coord_y;
        logic [9:0]        point_index;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  nearest_index;
        logic [32:0] nearest_distance;
        logic [10:0] vertex_total;
        logic [8:0]  polyline_total;
    } t_out;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture item
        logic write_new; // write point at count
        logic write_idx; // write point at index
        logic inc_last;  // bump last line length
        logic new_line;  // new line of length one
        logic pt_step;   // shift one point down
        logic pt_drop;   // point count down by one
        logic srch_init;
        logic srch_step;
        logic ln_step;   // find owning line
        logic ln_shift;  // shift one line length down
        logic finish;    // form result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] kind;
        logic no_lines;
        logic pts_full;
        logic lines_full;
        logic pts_empty;
        logic idx_bad;
        logic pt_done;
        logic srch_done;
        logic ln_found;
        logic ln_zero;
        logic ln_done;
    } t_sts;
endpackage
`default_nettype wire

/* sv/pps_if.sv */
// ----------------------------------------------------------------------------
// pps_if
// Valid/ready channel carrying one item.
// ----------------------------------------------------------------------------
`default_nettype none
interface pps_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/pps_ctrl.sv */
// ----------------------------------------------------------------------------
// pps_ctrl
// Sequencer for the point store: one item at a time.
// ----------------------------------------------------------------------------
`default_nettype none
module pps_ctrl import pps_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_res_valid,
    input  wire logic i_res_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DEC   = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_LINE  = 3'd3;
    localparam logic [2:0] S_LSH   = 3'd4;
    localparam logic [2:0] S_SRCH  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_res_valid, n_res_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE) && (!r_res_valid || i_res_ready);
    assign o_res_valid = r_res_valid;

    always_comb begin
        n_state     = r_state;
        n_res_valid = r_res_valid && !i_res_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                n_state = S_OUT;
                case (i_sts.kind)
                    K_APPEND, K_START: begin
                        if (!i_sts.pts_full && !((i_sts.kind == K_START || i_sts.no_lines)
                                && i_sts.lines_full)) begin
                            o_cmd.write_new = 1'b1;
                            if (i_sts.kind == K_START || i_sts.no_lines)
                                o_cmd.new_line = 1'b1;
                            else
                                o_cmd.inc_last = 1'b1;
                        end
                    end
                    K_UPDATE: begin
                        if (!i_sts.pts_empty && !i_sts.idx_bad) o_cmd.write_idx = 1'b1;
                    end
                    K_DELETE: begin
                        if (!i_sts.pts_empty && !i_sts.idx_bad) n_state = S_SHIFT;
                    end
                    K_SEARCH: begin
                        if (!i_sts.pts_empty) begin
                            o_cmd.srch_init = 1'b1;
                            n_state         = S_SRCH;
                        end
                    end
                    default: n_state = S_OUT;
                endcase
            end
            S_SHIFT: begin
                if (i_sts.pt_done) begin
                    o_cmd.pt_drop = 1'b1;
                    n_state       = S_LINE;
                end else o_cmd.pt_step = 1'b1;
            end
            S_LINE: begin
                o_cmd.ln_step = 1'b1;
                if (i_sts.ln_found) n_state = i_sts.ln_zero ? S_LSH : S_OUT;
            end
            S_LSH: begin
                o_cmd.ln_shift = 1'b1;
                if (i_sts.ln_done) n_state = S_OUT;
            end
            S_SRCH: begin
                o_cmd.srch_step = 1'b1;
                if (i_sts.srch_done) n_state = S_OUT;
            end
            S_OUT: begin
                o_cmd.finish = 1'b1;
                n_res_valid  = 1'b1;
                n_state      = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

/* sv/pps_dp.sv */
// ----------------------------------------------------------------------------
// pps_dp
// Point and line-length memories, counters, distance pipeline and result.
// ----------------------------------------------------------------------------
`default_nettype none
module pps_dp import pps_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_in  i_item,
    input  wire t_cmd i_cmd,
    output t_sts      o_sts,
    output t_out      o_res
);
    logic [31:0]    r_pmem [MaxPoints];
    logic [PCW-1:0] r_lmem [MaxLines];

    logic [PCW-1:0] r_pcnt;
    logic [LCW-1:0] r_lcnt;
    t_in            r_item;
    t_out           r_res;

    // point read port
    logic [PAW-1:0] r_prd_addr, n_prd_addr;
    logic [31:0]    r_prd;
    // line read port
    logic [LAW-1:0] r_lrd_addr, n_lrd_addr;
    logic [PCW-1:0] r_lrd;

    logic [PCW-1:0] r_pi;     // walk index (points)
    logic [LCW-1:0] r_li;     // walk index (lines)
    logic [PCW-1:0] r_begin;
    logic [1:0]     r_ph;     // read-latency phase
    logic           r_found_hit;

    // search pipeline
    logic [PCW-1:0] r_rd_i;   // issued read index
    logic           r_v1, r_v2;
    logic [PAW-1:0] r_i1, r_i2;
    logic [33:0]    r_sx, r_sy;
    logic [DW-1:0]  r_best;
    logic [PAW-1:0] r_best_i;
    logic           r_have;

    // item outcome flags captured at decode
    logic r_res_full, r_was_empty, r_was_bad, r_dec;

    wire logic [PCW-1:0] w_idx = PCW'(r_item.point_index);
    wire logic           w_new_line = i_cmd.new_line;

    always_comb begin
        o_sts.kind       = r_item.kind;
        o_sts.no_lines   = (r_lcnt == '0);
        o_sts.pts_full   = (r_pcnt == PCW'(MaxPoints));
        o_sts.lines_full = (r_lcnt == LCW'(MaxLines));
        o_sts.pts_empty  = (r_pcnt == '0);
        o_sts.idx_bad    = (w_idx >= r_pcnt);
        o_sts.pt_done    = (r_pi + 1'b1 >= r_pcnt) && (r_ph == 2'd0);
        o_sts.srch_done  = !r_v1 && !r_v2 && (r_rd_i >= r_pcnt) && r_have;
        o_sts.ln_found   = r_found_hit;
        o_sts.ln_zero    = (r_lrd == PCW'(1));
        o_sts.ln_done    = (r_li + 1'b1 >= r_lcnt) && (r_ph == 2'd1);
    end

    // read address selection
    always_comb begin
        n_prd_addr = r_prd_addr;
        n_lrd_addr = r_lrd_addr;
        if (i_cmd.pt_step && r_ph == 2'd0) n_prd_addr = PAW'(r_pi + 1'b1);
        if (i_cmd.srch_init) n_prd_addr = '0;
        if (i_cmd.srch_step) n_prd_addr = PAW'(r_rd_i);
        if (i_cmd.inc_last) n_lrd_addr = LAW'(r_lcnt - 1'b1);
        if (i_cmd.ln_step && r_ph == 2'd0) n_lrd_addr = LAW'(r_li);
        if (i_cmd.ln_shift && r_ph == 2'd0) n_lrd_addr = LAW'(r_li + 1'b1);
    end

    always_ff @(posedge i_clk) begin
        r_prd_addr <= n_prd_addr;
        r_lrd_addr <= n_lrd_addr;
        r_prd      <= r_pmem[n_prd_addr];
        r_lrd      <= r_lmem[n_lrd_addr];
    end

    // point memory writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.write_new) r_pmem[PAW'(r_pcnt)] <= {r_item.coord_x, r_item.coord_y};
        else if (i_cmd.write_idx) r_pmem[PAW'(w_idx)] <= {r_item.coord_x, r_item.coord_y};
        else if (i_cmd.pt_step && r_ph == 2'd1) r_pmem[PAW'(r_pi)] <= r_prd;
    end

    // line memory writes; inc_last uses the stall-free read-modify-write below
    logic r_inc_pend;
    always_ff @(posedge i_clk) begin
        if (w_new_line) r_lmem[LAW'(r_lcnt)] <= PCW'(1);
        else if (r_inc_pend) r_lmem[r_lrd_addr] <= r_lrd + 1'b1;
        else if (i_cmd.ln_step && r_found_hit) r_lmem[LAW'(r_li)] <= r_lrd - 1'b1;
        else if (i_cmd.ln_shift && r_ph == 2'd1) r_lmem[LAW'(r_li)] <= r_lrd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcnt     <= '0;
            r_lcnt     <= '0;
            r_inc_pend <= 1'b0;
        end else begin
            r_inc_pend <= i_cmd.inc_last;
            if (i_cmd.write_new) r_pcnt <= r_pcnt + 1'b1;
            if (w_new_line) r_lcnt <= r_lcnt + 1'b1;
            if (i_cmd.pt_drop) r_pcnt <= r_pcnt - 1'b1;
            if (i_cmd.ln_shift && o_sts.ln_done) r_lcnt <= r_lcnt - 1'b1;
        end
    end

    // walks
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item      <= i_item;
            r_ph        <= 2'd0;
            r_li        <= '0;
            r_begin     <= '0;
            r_found_hit <= 1'b0;
        end
        if (i_cmd.load) r_pi <= PCW'(i_item.point_index);
        if (i_cmd.pt_step) begin
            if (r_ph == 2'd0) r_ph <= 2'd1;
            else begin
                r_ph <= 2'd0;
                r_pi <= r_pi + 1'b1;
            end
        end
        if (i_cmd.ln_step) begin
            if (r_found_hit) begin
                r_found_hit <= 1'b0;
                r_ph        <= 2'd0;
            end else if (r_ph == 2'd0) r_ph <= 2'd1;
            else if (r_ph == 2'd1) r_ph <= 2'd2;
            else begin
                r_ph <= 2'd0;
                if (w_idx < r_begin + r_lrd) r_found_hit <= 1'b1;
                else begin
                    r_begin <= r_begin + r_lrd;
                    r_li    <= r_li + 1'b1;
                end
            end
        end
        if (i_cmd.ln_shift) begin
            if (r_ph == 2'd0) r_ph <= 2'd1;
            else begin
                r_ph <= 2'd0;
                r_li <= r_li + 1'b1;
            end
        end
    end

    // search: read, square, compare
    logic signed [16:0] w_dx, w_dy;
    logic [16:0]        w_ax, w_ay;
    logic [DW:0]        w_sum;
    logic [DW-1:0]      w_d;
    assign w_dx  = 17'($signed(r_item.coord_x)) - 17'($signed(r_prd[31:16]));
    assign w_dy  = 17'($signed(r_item.coord_y)) - 17'($signed(r_prd[15:0]));
    assign w_ax  = w_dx[16] ? 17'(-w_dx) : 17'(w_dx);
    assign w_ay  = w_dy[16] ? 17'(-w_dy) : 17'(w_dy);
    assign w_sum = 34'(r_sx) + 34'(r_sy);
    assign w_d   = w_sum[DW] ? {DW{1'b1}} : w_sum[DW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.srch_init) begin
            r_rd_i <= PCW'(1);
            r_v1   <= 1'b1;
            r_v2   <= 1'b0;
            r_i1   <= '0;
            r_have <= 1'b0;
        end else if (i_cmd.srch_step) begin
            r_v1 <= r_rd_i < r_pcnt;
            r_i1 <= PAW'(r_rd_i);
            if (r_rd_i < r_pcnt) r_rd_i <= r_rd_i + 1'b1;
            r_v2 <= r_v1;
            r_i2 <= r_i1;
            r_sx <= 34'(w_ax) * 34'(w_ax);
            r_sy <= 34'(w_ay) * 34'(w_ay);
            if (r_v2 && (!r_have || w_d < r_best)) begin
                r_best   <= w_d;
                r_best_i <= r_i2;
                r_have   <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_res.nearest_index    <= '0;
            r_res.nearest_distance <= '0;
            r_res.vertex_total     <= 11'(r_pcnt);
            r_res.polyline_total   <= 9'(r_lcnt);
            r_res.status           <= ST_OK;
            case (r_item.kind)
                K_APPEND, K_START: begin
                    if (r_res_full) r_res.status <= ST_FULL;
                end
                K_UPDATE, K_DELETE: begin
                    if (r_was_empty) r_res.status <= ST_EMPTY;
                    else if (r_was_bad) r_res.status <= ST_INDEX;
                end
                K_SEARCH: begin
                    if (r_was_empty) r_res.status <= ST_EMPTY;
                    else begin
                        r_res.nearest_index    <= 10'(r_best_i);
                        r_res.nearest_distance <= r_best;
                    end
                end
                default: r_res.status <= ST_OK;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_dec <= i_cmd.load;
        if (r_dec) begin
            r_res_full  <= o_sts.pts_full || ((r_item.kind == K_START || o_sts.no_lines)
                           && o_sts.lines_full);
            r_was_empty <= o_sts.pts_empty;
            r_was_bad   <= o_sts.idx_bad;
        end
    end

    assign o_res = r_res;
endmodule
`default_nettype wire

/* sv/polyline_point_store_nearest.sv */
// ----------------------------------------------------------------------------
// polyline_point_store_nearest
// Ordered 2D point store in polylines with linear nearest-point search.
// ----------------------------------------------------------------------------
// Throughput: one item at a time, set by the sequencer, which takes a new item only when idle.
// Reset: synchronous, active low; clears the sequencer state, the result valid
//   and the point and line counts; the memories are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module polyline_point_store_nearest import pps_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pps_if.sink       i_item,
    pps_if.source     o_result
);
    t_cmd w_cmd;
    t_sts w_sts;

    pps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_res_valid (o_result.valid),
        .i_res_ready (o_result.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    pps_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item.data),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_res   (o_result.data)
    );
endmodule
`default_nettype wire

/* sv/pps_checker.sv */
// ----------------------------------------------------------------------------
// pps_checker
// Port-level checks on the point store.
// ----------------------------------------------------------------------------
`default_nettype none
module pps_checker import pps_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire t_out i_out
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out))
        else $error("result dropped while stalled");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("item taken while busy");
    a_vtx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out.vertex_total <= 11'(MaxPoints))
        else $error("vertex total out of range");
    a_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> 11'(i_out.polyline_total) <= i_out.vertex_total)
        else $error("more lines than points");
endmodule

bind polyline_point_store_nearest pps_checker u_pps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out       (o_result.data)
);
`default_nettype wire
